### sv/skt_pkg.sv
package skt_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KEY_BYTES_DEF   = 8;
    localparam int DATA_BITS_DEF   = 32;

    localparam int KEY_PORT_W    = 64;
    localparam int DATA_PORT_W   = 32;
    localparam int STATUS_W      = 2;
    localparam int INDEX_PORT_W  = 6;
    localparam int COUNT_PORT_W  = 7;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic cmp_en;
        logic ins_en;
    } cell_ctrl_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cell_flag_t;

endpackage

### sv/skt_cell.sv
module skt_cell #(
    parameter int KEY_W  = 64,
    parameter int DATA_W = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  skt_pkg::cell_ctrl_t     ctrl,
    input  logic                    occupied,
    input  logic [KEY_W-1:0]        cmp_key,
    input  logic [KEY_W-1:0]        new_key,
    input  logic [DATA_W-1:0]       new_data,
    input  logic                    prev_le,
    input  logic [KEY_W-1:0]        prev_key,
    input  logic [DATA_W-1:0]       prev_data,
    output logic [KEY_W-1:0]        key_reg,
    output logic [DATA_W-1:0]       data_reg,
    output skt_pkg::cell_flag_t     flag_reg
);

    logic [KEY_W-1:0]    key_next;
    logic [DATA_W-1:0]   data_next;
    skt_pkg::cell_flag_t flag_next;
    logic                my_le;

    assign my_le = flag_reg.lt | flag_reg.eq;

    always_comb begin
        key_next  = key_reg;
        data_next = data_reg;
        flag_next = flag_reg;
        if (ctrl.cmp_en) begin
            flag_next.lt = occupied && (key_reg < cmp_key);
            flag_next.eq = occupied && (key_reg == cmp_key);
        end
        if (ctrl.ins_en && !my_le) begin
            if (prev_le) begin
                key_next  = new_key;
                data_next = new_data;
            end else begin
                key_next  = prev_key;
                data_next = prev_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        data_reg <= data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg <= '0;
        end else begin
            flag_reg <= flag_next;
        end
    end

endmodule

### sv/sorted_key_table_core.sv
// Sorted key table: a row of cells holding entries in ascending key order.
// Input channel (s_valid/s_ready) takes one command beat: an insert of
// s_key with s_entry_data, or a lookup of s_key. The result channel
// (m_valid/m_ready) returns exactly one beat per command with status,
// entry index, found data and match count.
// Every cell compares the broadcast key in the cycle of acceptance; in the
// evaluation state that follows, the boundary of the compare flags is
// encoded and, on an insert, every cell above the insert point takes its
// lower neighbour's entry in parallel, once the output register is free.
// The result beat is then written to the output register. One command is
// handled at a time: the next is accepted only after the evaluation state
// has been left.
// A new command is accepted while an earlier result beat still waits; if
// the receiver stalls, that command holds in the evaluation state until the
// output register is free, and no further command is accepted meanwhile.
// Reset empties the table at once; stored entries are not cleared.
// Inserts into a full table are refused with status full.
module sorted_key_table_core #(
    parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BYTES   = skt_pkg::KEY_BYTES_DEF,
    parameter int DATA_BITS   = skt_pkg::DATA_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic [skt_pkg::KEY_PORT_W-1:0]      s_key,
    input  logic [skt_pkg::DATA_PORT_W-1:0]     s_entry_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [skt_pkg::STATUS_W-1:0]        m_status,
    output logic [skt_pkg::INDEX_PORT_W-1:0]    m_entry_index,
    output logic [skt_pkg::DATA_PORT_W-1:0]     m_found_data,
    output logic [skt_pkg::COUNT_PORT_W-1:0]    m_match_count
);

    localparam int KEY_W = 8 * KEY_BYTES;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EVAL = 2'b10
    } skt_state_t;

    skt_state_t state_reg, state_next;

    logic                 cmd_reg;
    logic [KEY_W-1:0]     nkey_reg;
    logic [DATA_BITS-1:0] ndata_reg;
    logic [CNT_W-1:0]     count_reg, count_next;

    logic                                 m_valid_reg, m_valid_next;
    logic [skt_pkg::STATUS_W-1:0]         m_status_reg, m_status_next;
    logic [skt_pkg::INDEX_PORT_W-1:0]     m_index_reg, m_index_next;
    logic [skt_pkg::DATA_PORT_W-1:0]      m_data_reg, m_data_next;
    logic [skt_pkg::COUNT_PORT_W-1:0]     m_count_reg, m_count_next;

    logic                 accept;
    logic                 eval_fire;
    logic                 full;
    logic                 ins_en;
    skt_pkg::cell_ctrl_t  ctrl;

    logic [KEY_W-1:0]          cell_key  [TABLE_DEPTH];
    logic [DATA_BITS-1:0]      cell_data [TABLE_DEPTH];
    skt_pkg::cell_flag_t       cell_flag [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]    lt_vec, le_vec, eq_vec, lt_bnd, le_bnd;

    logic [IDX_W-1:0]     lo_sel, hi_sel;
    logic                 hit;
    logic [DATA_BITS-1:0] hit_data;
    logic [CNT_W-1:0]     hi_cnt, match_cnt;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign eval_fire = (state_reg == ST_EVAL) && (!m_valid_reg || m_ready);
    assign full      = (count_reg == CNT_W'(TABLE_DEPTH));
    assign ins_en    = eval_fire && (cmd_reg == skt_pkg::CMD_INSERT) && !full;

    assign ctrl.cmp_en = accept;
    assign ctrl.ins_en = ins_en;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        logic             prev_le;
        logic [KEY_W-1:0] prev_key;
        logic [DATA_BITS-1:0] prev_data;

        if (i == 0) begin : g_first
            assign prev_le   = 1'b1;
            assign prev_key  = '0;
            assign prev_data = '0;
            assign lt_bnd[i] = !lt_vec[i];
            assign le_bnd[i] = !le_vec[i];
        end else begin : g_rest
            assign prev_le   = le_vec[i-1];
            assign prev_key  = cell_key[i-1];
            assign prev_data = cell_data[i-1];
            assign lt_bnd[i] = !lt_vec[i] && lt_vec[i-1];
            assign le_bnd[i] = !le_vec[i] && le_vec[i-1];
        end

        assign lt_vec[i] = cell_flag[i].lt;
        assign eq_vec[i] = cell_flag[i].eq;
        assign le_vec[i] = cell_flag[i].lt | cell_flag[i].eq;

        skt_cell #(
            .KEY_W  (KEY_W),
            .DATA_W (DATA_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .occupied  (CNT_W'(i) < count_reg),
            .cmp_key   (s_key[KEY_W-1:0]),
            .new_key   (nkey_reg),
            .new_data  (ndata_reg),
            .prev_le   (prev_le),
            .prev_key  (prev_key),
            .prev_data (prev_data),
            .key_reg   (cell_key[i]),
            .data_reg  (cell_data[i]),
            .flag_reg  (cell_flag[i])
        );
    end

    always_comb begin
        lo_sel   = '0;
        hi_sel   = '0;
        hit      = 1'b0;
        hit_data = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (lt_bnd[i]) begin
                lo_sel = lo_sel | IDX_W'(i);
            end
            if (le_bnd[i]) begin
                hi_sel = hi_sel | IDX_W'(i);
            end
            if (lt_bnd[i] && eq_vec[i]) begin
                hit      = 1'b1;
                hit_data = hit_data | cell_data[i];
            end
        end
        hi_cnt    = le_vec[TABLE_DEPTH-1] ? CNT_W'(TABLE_DEPTH) : CNT_W'(hi_sel);
        match_cnt = hi_cnt - CNT_W'(lo_sel);
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_index_next  = m_index_reg;
        m_data_next   = m_data_reg;
        m_count_next  = m_count_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (eval_fire) begin
                    state_next    = ST_IDLE;
                    m_valid_next  = 1'b1;
                    m_status_next = skt_pkg::STATUS_OK;
                    m_index_next  = '0;
                    m_data_next   = '0;
                    m_count_next  = '0;
                    if (cmd_reg == skt_pkg::CMD_INSERT) begin
                        if (full) begin
                            m_status_next = skt_pkg::STATUS_FULL;
                        end else begin
                            m_index_next = skt_pkg::INDEX_PORT_W'(hi_cnt);
                            count_next   = count_reg + CNT_W'(1);
                        end
                    end else begin
                        if (hit) begin
                            m_index_next = skt_pkg::INDEX_PORT_W'(lo_sel);
                            m_data_next  = skt_pkg::DATA_PORT_W'(hit_data);
                            m_count_next = skt_pkg::COUNT_PORT_W'(match_cnt);
                        end else begin
                            m_status_next = skt_pkg::STATUS_NOT_FOUND;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_index_reg  <= m_index_next;
        m_data_reg   <= m_data_next;
        m_count_reg  <= m_count_next;
        if (accept) begin
            cmd_reg   <= s_command;
            nkey_reg  <= s_key[KEY_W-1:0];
            ndata_reg <= DATA_BITS'(s_entry_data);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_index = m_index_reg;
    assign m_found_data  = m_data_reg;
    assign m_match_count = m_count_reg;

    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("Entry count exceeds the table depth.");

    a_lt_boundary : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL) |-> $onehot0(lt_bnd))
        else $error("Less-than flags are not a single thermometer.");

    a_le_boundary : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL) |-> $onehot0(le_bnd))
        else $error("Less-or-equal flags are not a single thermometer.");

    a_insert_count : assert property (@(posedge aclk) disable iff (!aresetn)
        ins_en |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("Insert did not advance the entry count.");

endmodule

### dv/sorted_key_table_core_tb.sv
`timescale 1ns / 100ps

module sorted_key_table_core_tb;

    localparam int DEPTH = skt_pkg::TABLE_DEPTH_DEF;

    typedef struct packed {
        logic [skt_pkg::STATUS_W-1:0]     status;
        logic [skt_pkg::INDEX_PORT_W-1:0] index;
        logic [skt_pkg::DATA_PORT_W-1:0]  data;
        logic [skt_pkg::COUNT_PORT_W-1:0] count;
    } table_reply_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_valid;
    logic                             s_ready;
    logic                             s_command;
    logic [skt_pkg::KEY_PORT_W-1:0]   s_key;
    logic [skt_pkg::DATA_PORT_W-1:0]  s_entry_data;
    logic                             m_valid;
    logic                             m_ready;
    logic [skt_pkg::STATUS_W-1:0]     m_status;
    logic [skt_pkg::INDEX_PORT_W-1:0] m_entry_index;
    logic [skt_pkg::DATA_PORT_W-1:0]  m_found_data;
    logic [skt_pkg::COUNT_PORT_W-1:0] m_match_count;

    logic [skt_pkg::KEY_PORT_W-1:0]  row_key [DEPTH];
    logic [skt_pkg::DATA_PORT_W-1:0] row_data [DEPTH];
    int                              row_count;
    logic [skt_pkg::KEY_PORT_W-1:0]  name_pool [16];

    table_reply_t pending_replies [$];
    int           error_count;
    int           mismatch_count;
    bit           tx_idle;
    bit           rx_idle;
    int           rx_hold_cycles;

    sorted_key_table_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_key         (s_key),
        .s_entry_data  (s_entry_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_index (m_entry_index),
        .m_found_data  (m_found_data),
        .m_match_count (m_match_count)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("sorted_key_table_core_tb: errors");
        $finish;
    end

    function automatic table_reply_t apply_command(logic cmd,
                                                   logic [skt_pkg::KEY_PORT_W-1:0] key,
                                                   logic [skt_pkg::DATA_PORT_W-1:0] data);
        table_reply_t r;
        int lo;
        int hi;
        int i;
        r  = '0;
        lo = 0;
        hi = 0;
        for (i = 0; i < row_count; i++) begin
            if (row_key[i] < key) lo++;
            if (row_key[i] <= key) hi++;
        end
        if (cmd == skt_pkg::CMD_INSERT) begin
            if (row_count >= DEPTH) begin
                r.status = skt_pkg::STATUS_FULL;
            end else begin
                for (i = row_count; i > hi; i--) begin
                    row_key[i]  = row_key[i-1];
                    row_data[i] = row_data[i-1];
                end
                row_key[hi]  = key;
                row_data[hi] = data;
                row_count++;
                r.status = skt_pkg::STATUS_OK;
                r.index  = hi[skt_pkg::INDEX_PORT_W-1:0];
            end
        end else if (hi > lo) begin
            r.status = skt_pkg::STATUS_OK;
            r.index  = lo[skt_pkg::INDEX_PORT_W-1:0];
            r.data   = row_data[lo];
            r.count  = skt_pkg::COUNT_PORT_W'(hi - lo);
        end else begin
            r.status = skt_pkg::STATUS_NOT_FOUND;
        end
        return r;
    endfunction

    function automatic logic [skt_pkg::KEY_PORT_W-1:0] pick_key(bit favour_stored);
        logic [skt_pkg::KEY_PORT_W-1:0] k;
        int mode;
        mode = $urandom_range(0, favour_stored ? 11 : 7);
        k = name_pool[$urandom_range(0, 15)];
        if (mode == 4) begin
            k = {$urandom, $urandom};
        end else if (mode == 5) begin
            k = k ^ (64'd1 << $urandom_range(0, 63));
        end else if (mode == 6) begin
            k = $urandom_range(0, 1) ? '1 : '0;
        end else if (mode >= 7 && row_count > 0) begin
            k = row_key[$urandom_range(0, row_count - 1)];
        end
        return k;
    endfunction

    task automatic send_beat(logic cmd, logic [skt_pkg::KEY_PORT_W-1:0] key,
                             logic [skt_pkg::DATA_PORT_W-1:0] data);
        int gap;
        gap = tx_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_key        <= key;
        s_entry_data <= data;
        do @(posedge aclk); while (!(s_valid && s_ready));
        pending_replies.push_back(apply_command(cmd, key, data));
    endtask

    task automatic send_random_beat(int insert_weight);
        if ($urandom_range(0, 99) < insert_weight) begin
            send_beat(skt_pkg::CMD_INSERT, pick_key(1'b0), $urandom);
        end else begin
            send_beat(skt_pkg::CMD_LOOKUP, pick_key(1'b1), $urandom);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            int gap;
            if (rx_hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end
            gap = rx_idle ? $urandom_range(0, 12) : 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    initial begin
        table_reply_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_replies.size() == 0) begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected result beat: status %0d index %0d data %h count %0d",
                                 m_status, m_entry_index, m_found_data, m_match_count);
                    end
                end else begin
                    want = pending_replies.pop_front();
                    if (m_status !== want.status || m_entry_index !== want.index ||
                        m_found_data !== want.data || m_match_count !== want.count) begin
                        error_count++;
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch: expected status %0d index %0d data %h count %0d",
                                     want.status, want.index, want.data, want.count);
                            $display("          actual   status %0d index %0d data %h count %0d",
                                     m_status, m_entry_index, m_found_data, m_match_count);
                        end
                    end
                end
            end
        end
    end

    task automatic test_directed();
        send_beat(skt_pkg::CMD_LOOKUP, '0, '1);
        send_beat(skt_pkg::CMD_LOOKUP, '1, '0);
        send_beat(skt_pkg::CMD_INSERT, '0, '0);
        send_beat(skt_pkg::CMD_INSERT, '1, '1);
        send_beat(skt_pkg::CMD_INSERT, 64'h4100_0000_0000_0000, 32'h0000_0001);
        send_beat(skt_pkg::CMD_INSERT, 64'h6162_0000_0000_0000, 32'h1111_1111);
        send_beat(skt_pkg::CMD_INSERT, 64'h6162_0000_0000_0000, 32'h2222_2222);
        send_beat(skt_pkg::CMD_INSERT, 64'h6162_0000_0000_0000, 32'h3333_3333);
        send_beat(skt_pkg::CMD_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0000);
        send_beat(skt_pkg::CMD_INSERT, 64'h7fff_ffff_ffff_ffff, 32'h7fff_ffff);
        send_beat(skt_pkg::CMD_LOOKUP, 64'h6162_0000_0000_0000, '0);
        send_beat(skt_pkg::CMD_LOOKUP, '0, '1);
        send_beat(skt_pkg::CMD_LOOKUP, '1, '0);
        send_beat(skt_pkg::CMD_LOOKUP, 64'h4100_0000_0000_0000, '0);
        send_beat(skt_pkg::CMD_LOOKUP, 64'h6161_0000_0000_0000, '0);
        send_beat(skt_pkg::CMD_LOOKUP, 64'h8000_0000_0000_0000, '0);
        send_beat(skt_pkg::CMD_LOOKUP, 64'h7fff_ffff_ffff_ffff, '0);
        send_beat(skt_pkg::CMD_LOOKUP, 64'h6162_0000_0000_0001, '0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        tx_idle = 1'b0;
        rx_hold_cycles = 120;
        repeat (16) send_random_beat(30);
        wait_drained();
        tx_idle = 1'b1;
    endtask

    task automatic test_random_traffic(int beats);
        for (int n = 0; n < beats; n++) begin
            if (n % 50 == 0) begin
                tx_idle = $urandom_range(0, 3) != 0;
                rx_idle = $urandom_range(0, 3) != 0;
            end
            send_random_beat(20);
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        wait_drained();
    endtask

    task automatic test_full_table();
        while (row_count < DEPTH) send_beat(skt_pkg::CMD_INSERT, pick_key(1'b0), $urandom);
        repeat (4) send_beat(skt_pkg::CMD_INSERT, pick_key(1'b0), $urandom);
        repeat (12) send_beat(skt_pkg::CMD_LOOKUP, pick_key(1'b1), $urandom);
        send_beat(skt_pkg::CMD_LOOKUP, row_key[0], '0);
        send_beat(skt_pkg::CMD_LOOKUP, row_key[DEPTH-1], '0);
        wait_drained();
    endtask

    initial begin
        logic [7:0] ch;
        int len;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_command      <= skt_pkg::CMD_INSERT;
        s_key          <= '0;
        s_entry_data   <= '0;
        row_count      = 0;
        error_count    = 0;
        mismatch_count = 0;
        tx_idle        = 1'b1;
        rx_idle        = 1'b1;
        rx_hold_cycles = 0;
        for (int i = 0; i < 16; i++) begin
            len = $urandom_range(1, 8);
            name_pool[i] = '0;
            for (int b = 0; b < 8; b++) begin
                ch = (b < len) ? 8'($urandom_range(8'h61, 8'h7a)) : 8'h00;
                name_pool[i] = {name_pool[i][55:0], ch};
            end
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure();
        test_random_traffic(520);
        test_full_table();

        wait_drained();
        if (error_count == 0) begin
            $display("sorted_key_table_core_tb: clean");
        end else begin
            $display("sorted_key_table_core_tb: errors");
        end
        $finish;
    end

endmodule
